[rtl/assert_macros.svh]
// Assertion macros for the sorted list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sorted list engine check failed");

// When the first expression holds, the second must hold in the next cycle.
`define SLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list engine check failed");

`endif

[rtl/sle_pkg.sv]
// Types and constants shared by the sorted list engine modules.
package sle_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int ITEM_WIDTH_DEFAULT = 32;
    localparam int OP_W               = 3;
    localparam int STATUS_W           = 3;
    localparam int PORT_ITEM_W        = 32;
    localparam int TREE_GROUP         = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_POP    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_ORDER     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_FIND,
        ST_EXEC,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_APPEND,
        CMD_REMOVE,
        CMD_POP
    } t_cell_cmd;

    typedef struct packed {
        logic      compare;
        t_cell_cmd update;
    } t_cell_ctl;

endpackage

[rtl/sle_cell.sv]
// One storage cell of the sorted chain: holds one item and its compare flags.
module sle_cell #(
    parameter int ITEM_WIDTH = sle_pkg::ITEM_WIDTH_DEFAULT,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  sle_pkg::t_cell_ctl    i_ctl,
    input  logic [ITEM_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [ITEM_WIDTH-1:0] i_left_data,
    input  logic                  i_left_le,
    input  logic [ITEM_WIDTH-1:0] i_right_data,
    output logic [ITEM_WIDTH-1:0] o_data,
    output logic                  o_le,
    output logic                  o_hit_eq,
    output logic                  o_hit_gt,
    output logic [ITEM_WIDTH-1:0] o_tail_word
);
    import sle_pkg::*;

    localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

    logic [ITEM_WIDTH-1:0] r_data;
    logic                  r_le;
    logic                  r_lt;
    logic                  r_eq;
    logic                  w_valid;
    logic                  w_last;

    assign w_valid = IDX < i_count;
    // An empty store has no last cell, even where the index above the top cell wraps to zero.
    assign w_last  = (i_count != '0) && (IDX_NEXT == i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            r_le <= w_valid && (r_data <= i_key);
            r_lt <= w_valid && (r_data < i_key);
            r_eq <= w_valid && (r_data == i_key);
        end
        case (i_ctl.update)
            CMD_INSERT: begin
                if (!r_le) begin
                    r_data <= i_left_le ? i_key : i_left_data;
                end
            end
            CMD_APPEND: begin
                if (IDX == i_count) begin
                    r_data <= i_key;
                end
            end
            CMD_REMOVE: begin
                if (!r_lt) begin
                    r_data <= i_right_data;
                end
            end
            CMD_POP: begin
                r_data <= i_right_data;
            end
            default: begin
            end
        endcase
    end

    assign o_data      = r_data;
    assign o_le        = r_le;
    assign o_hit_eq    = r_eq;
    assign o_hit_gt    = w_valid && !r_le;
    assign o_tail_word = w_last ? r_data : '0;

endmodule

[rtl/sle_or_tree.sv]
// Two-level OR reduction over the cell taps, with registered group results.
module sle_or_tree #(
    parameter int WIDTH = 34,
    parameter int N     = sle_pkg::DEPTH_DEFAULT,
    parameter int GROUP = sle_pkg::TREE_GROUP
) (
    input  logic                      i_clk,
    input  logic [N-1:0][WIDTH-1:0]   i_taps,
    output logic [WIDTH-1:0]          o_any
);
    import sle_pkg::*;

    localparam int NG = (N + GROUP - 1) / GROUP;

    logic [NG-1:0][WIDTH-1:0] r_grp;
    logic [NG-1:0][WIDTH-1:0] n_grp;

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int m = 0; m < GROUP; m++) begin
                if (g * GROUP + m < N) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GROUP + m];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    always_comb begin
        o_any = '0;
        for (int g = 0; g < NG; g++) begin
            o_any = o_any | r_grp[g];
        end
    end

endmodule

[rtl/sorted_list_engine.sv]
// Top level of the sorted list engine: sequencer, cell chain and result register.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+--------------------------------------
//  request  | in        | i_in_valid / o_in_ready    | i_op, i_item
//  result   | out       | o_out_valid / i_out_ready  | o_status, o_out_item, o_is_member,
//           |           |                            | o_count, o_head_item, o_tail_item
//
// A request passes from acceptance to the result appearing in the output register
// through these steps in order: every cell compares its item with the key, the grouped
// OR of the match flags is registered, every cell shifts or loads in parallel, the
// grouped OR that picks out the tail item is registered, and the result is loaded.
// The two passes go through the registered OR tree over the cells; the next request is
// taken in the cycle after the load, so no new request is taken while one is in flight.
// Reset (i_rst_n low at a clock edge) empties the store and drops any pending result.
// The result register parts the two sides: a new request is taken while an earlier
// result still waits; only the loading of the next result waits for i_out_ready.
module sorted_list_engine #(
    parameter int DEPTH      = sle_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = sle_pkg::ITEM_WIDTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sle_pkg::OP_W-1:0]          i_op,
    input  logic [sle_pkg::PORT_ITEM_W-1:0]   i_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sle_pkg::STATUS_W-1:0]      o_status,
    output logic [sle_pkg::PORT_ITEM_W-1:0]   o_out_item,
    output logic                              o_is_member,
    output logic [$clog2(DEPTH+1)-1:0]        o_count,
    output logic [sle_pkg::PORT_ITEM_W-1:0]   o_head_item,
    output logic [sle_pkg::PORT_ITEM_W-1:0]   o_tail_item
);
    import sle_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TAP_W    = ITEM_WIDTH + 2;
    localparam int COPY_IN  = (ITEM_WIDTH < PORT_ITEM_W) ? ITEM_WIDTH : PORT_ITEM_W;
    localparam int COPY_OUT = COPY_IN;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Sequencer and request registers.
    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [OP_W-1:0]         r_op;
    logic [ITEM_WIDTH-1:0]   r_key;
    logic [ITEM_WIDTH-1:0]   w_key_in;

    // Outcome of the update cycle, held until the result is loaded.
    t_status                 r_status;
    t_status                 n_status;
    logic [ITEM_WIDTH-1:0]   r_taken;
    logic [ITEM_WIDTH-1:0]   n_taken;
    logic                    r_member;
    logic                    n_member;

    // Result register.
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic                    w_load;
    t_status                 r_out_status;
    logic [PORT_ITEM_W-1:0]  r_out_item;
    logic                    r_out_member;
    logic [CNT_W-1:0]        r_out_count;
    logic [PORT_ITEM_W-1:0]  r_out_head;
    logic [PORT_ITEM_W-1:0]  r_out_tail;
    logic [PORT_ITEM_W-1:0]  w_taken_port;
    logic [PORT_ITEM_W-1:0]  w_head_port;
    logic [PORT_ITEM_W-1:0]  w_tail_port;

    // Cell chain and reduction.
    t_cell_ctl                          w_ctl;
    logic [DEPTH-1:0][ITEM_WIDTH-1:0]   w_data;
    logic [DEPTH-1:0]                   w_le;
    logic [DEPTH-1:0]                   w_hit_eq;
    logic [DEPTH-1:0]                   w_hit_gt;
    logic [DEPTH-1:0][ITEM_WIDTH-1:0]   w_tail_word;
    logic [DEPTH-1:0][TAP_W-1:0]        w_taps;
    logic [TAP_W-1:0]                   w_any;
    logic                               w_found;
    logic                               w_gt_any;

    // The key is the request item taken modulo 2^ITEM_WIDTH.
    always_comb begin
        w_key_in = '0;
        for (int b = 0; b < COPY_IN; b++) begin
            w_key_in[b] = i_item[b];
        end
    end

    // Each cell sees its neighbours' items; the ends of the chain see zeros, and the
    // first cell sees a left neighbour whose item is never above the key, so an insert
    // at the head loads the key there.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [ITEM_WIDTH-1:0] w_left_data;
        logic                  w_left_le;
        logic [ITEM_WIDTH-1:0] w_right_data;

        if (k == 0) begin : g_first
            assign w_left_data = '0;
            assign w_left_le   = 1'b1;
        end else begin : g_inner
            assign w_left_data = w_data[k-1];
            assign w_left_le   = w_le[k-1];
        end

        if (k == DEPTH - 1) begin : g_end
            assign w_right_data = '0;
        end else begin : g_mid
            assign w_right_data = w_data[k+1];
        end

        sle_cell #(
            .ITEM_WIDTH (ITEM_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_count      (r_count),
            .i_left_data  (w_left_data),
            .i_left_le    (w_left_le),
            .i_right_data (w_right_data),
            .o_data       (w_data[k]),
            .o_le         (w_le[k]),
            .o_hit_eq     (w_hit_eq[k]),
            .o_hit_gt     (w_hit_gt[k]),
            .o_tail_word  (w_tail_word[k])
        );

        assign w_taps[k] = {w_hit_eq[k], w_hit_gt[k], w_tail_word[k]};
    end

    // The same tree serves twice: after the compare cycle its top bits say whether the
    // key is held and whether any held item lies above it; after the update cycle its
    // low bits carry the item of the one cell that is now last.
    sle_or_tree #(
        .WIDTH (TAP_W),
        .N     (DEPTH),
        .GROUP (TREE_GROUP)
    ) u_tree (
        .i_clk  (i_clk),
        .i_taps (w_taps),
        .o_any  (w_any)
    );

    assign w_found  = w_any[TAP_W-1];
    assign w_gt_any = w_any[TAP_W-2];

    // Next state, cell commands and the outcome of the request.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_status       = r_status;
        n_taken        = r_taken;
        n_member       = r_member;
        w_ctl.compare  = 1'b0;
        w_ctl.update   = CMD_HOLD;
        w_load         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                w_ctl.compare = 1'b1;
                n_state       = ST_FIND;
            end
            ST_FIND: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_status = STAT_OK;
                n_taken  = '0;
                n_member = 1'b0;
                case (r_op)
                    OP_INSERT: begin
                        if (r_count == FULL_COUNT) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_ctl.update = CMD_INSERT;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                    OP_APPEND: begin
                        if (r_count == FULL_COUNT) begin
                            n_status = STAT_FULL;
                        end else if (w_gt_any) begin
                            n_status = STAT_ORDER;
                        end else begin
                            w_ctl.update = CMD_APPEND;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else if (!w_found) begin
                            n_status = STAT_NOT_FOUND;
                        end else begin
                            w_ctl.update = CMD_REMOVE;
                            n_count      = r_count - CNT_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            w_ctl.update = CMD_POP;
                            n_taken      = w_data[0];
                            n_count      = r_count - CNT_W'(1);
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    OP_QUERY: begin
                        n_member = w_found;
                    end
                    default: begin
                    end
                endcase
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Result items are shown on fixed-width ports: wider items are cut, narrower ones
    // are zero-extended.
    always_comb begin
        w_taken_port = '0;
        w_head_port  = '0;
        w_tail_port  = '0;
        for (int b = 0; b < COPY_OUT; b++) begin
            w_taken_port[b] = r_taken[b];
            w_head_port[b]  = w_data[0][b] && (r_count != '0);
            w_tail_port[b]  = w_any[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_op  <= i_op;
            r_key <= w_key_in;
        end
        r_status <= n_status;
        r_taken  <= n_taken;
        r_member <= n_member;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_item   <= w_taken_port;
            r_out_member <= r_member;
            r_out_count  <= r_count;
            r_out_head   <= w_head_port;
            r_out_tail   <= w_tail_port;
        end
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_item  = r_out_item;
    assign o_is_member = r_out_member;
    assign o_count     = r_out_count;
    assign o_head_item = r_out_head;
    assign o_tail_item = r_out_tail;

    // The count can never pass the number of cells.
    `SLE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT)
    // Only the update cycle may change the count.
    `SLE_ASSERT_NEXT(a_count_only_exec, i_clk, i_rst_n, r_state != ST_EXEC, $stable(r_count))
    // A refused request leaves the store as it was.
    `SLE_ASSERT_NEXT(a_error_keeps_count, i_clk, i_rst_n, r_state == ST_EXEC && n_status != STAT_OK, $stable(r_count))
    // An accepted request always starts with the compare cycle.
    `SLE_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_CMP)
    // An empty store shows zero for both head and tail.
    `SLE_ASSERT(a_empty_zero, i_clk, i_rst_n, !r_out_valid || r_out_count != '0 || (r_out_head == '0 && r_out_tail == '0))

endmodule
